// ===== design/tlbpt_pkg.sv =====
// ----------------------------------------------------------------------------
// TLB and page table translator: shared definitions
// Field widths of the request and result ports, the source codes that tell
// where a translation came from, and the region codes of the tag memory.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

    // Fixed widths of the port fields.
    localparam int ADDR_W = 16;
    localparam int SRC_W  = 2;
    localparam int EVP_W  = 6;

    // Where a translation was found.
    localparam logic [SRC_W-1:0] SRC_TLB   = 2'd0;
    localparam logic [SRC_W-1:0] SRC_TABLE = 2'd1;
    localparam logic [SRC_W-1:0] SRC_FAULT = 2'd2;

    // The tag memory holds two tables side by side, picked by its top address bit.
    localparam logic REGION_SLOT  = 1'b0;
    localparam logic REGION_OWNER = 1'b1;

endpackage

// ===== design/tlbpt_ram.sv =====
// ----------------------------------------------------------------------------
// TLB and page table translator: generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tlbpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/tlb_page_table_translator.sv =====
// ----------------------------------------------------------------------------
// TLB and page table translator
// Splits a logical address into page and offset, looks the page up in a
// fully associative TLB and then in the page table, refills the TLB in FIFO
// order and hands out frames round-robin on a page fault, reporting the page
// that lost its frame.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+---------------------------------
//   request  | in        | i_valid / o_ready    | i_logical_address
//   result   | out       | o_valid / i_ready    | o_physical_address, o_source,
//            |           |                      | o_evicted_valid, o_evicted_page
//
// A TLB hit or a page table hit goes through LOOK_A, LOOK_B and DONE. A page
// fault goes on to OWNER, to OLD_A if the frame had an owner, to OLD_B if
// that page had a TLB slot, and to INSERT unless that slot is retargeted,
// then to DONE, following the chain of dependent reads of the page memory
// and the tag memory (one read each per cycle). After reset a clearing pass
// zeroes both memories, one entry per cycle; no request is taken meanwhile.
// A result waiting on i_ready holds the block in its final step, but the next
// request is taken in the same cycle that the result register is loaded.
// ----------------------------------------------------------------------------
module tlb_page_table_translator
    import tlbpt_pkg::*;
#(
    parameter int TLB_ENTRIES = 64,
    parameter int PAGE_COUNT  = 64,
    parameter int FRAME_COUNT = 64,
    parameter int OFFSET_BITS = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [ADDR_W-1:0] i_logical_address,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [ADDR_W-1:0] o_physical_address,
    output logic [SRC_W-1:0]  o_source,
    output logic              o_evicted_valid,
    output logic [EVP_W-1:0]  o_evicted_page
);

    localparam int PB    = $clog2(PAGE_COUNT);
    localparam int FB    = $clog2(FRAME_COUNT);
    localparam int TB    = $clog2(TLB_ENTRIES);
    localparam int XB    = (TB > FB) ? TB : FB;
    localparam int BAW   = XB + 1;
    localparam int BD    = 2 ** BAW;
    localparam int OB    = OFFSET_BITS;
    localparam int RAW_W = (OB >= ADDR_W) ? 1 : ADDR_W - OB;
    localparam int CLR_DEPTH = (PAGE_COUNT > BD) ? PAGE_COUNT : BD;
    localparam int CLW   = $clog2(CLR_DEPTH);

    // Page memory entry: the mapping and where the page last went in the TLB.
    typedef struct packed {
        logic          map_valid;
        logic [FB-1:0] frame;
        logic          in_tlb;
        logic [TB-1:0] slot;
    } t_page_entry;

    // Tag memory entry: TLB slot contents or the owner of a frame.
    typedef struct packed {
        logic          valid;
        logic [PB-1:0] page;
    } t_tag_entry;

    typedef enum logic [8:0] {
        S_CLEAR  = 9'b0_0000_0001,
        S_IDLE   = 9'b0_0000_0010,
        S_LOOK_A = 9'b0_0000_0100,
        S_LOOK_B = 9'b0_0000_1000,
        S_OWNER  = 9'b0_0001_0000,
        S_OLD_A  = 9'b0_0010_0000,
        S_OLD_B  = 9'b0_0100_0000,
        S_INSERT = 9'b0_1000_0000,
        S_DONE   = 9'b1_0000_0000
    } t_state;

    // Page number modulo PAGE_COUNT by conditional subtraction of shifted
    // copies; at the default sizes every step folds away to a mask.
    function automatic logic [PB-1:0] f_page_of(input logic [RAW_W-1:0] raw);
        logic [31:0] rem;
        rem = 32'(raw);
        for (int k = RAW_W; k >= 0; k--) begin
            if (rem >= (32'(PAGE_COUNT) << k)) begin
                rem = rem - (32'(PAGE_COUNT) << k);
            end
        end
        return PB'(rem);
    endfunction

    // Control state.
    t_state          r_state, n_state;
    logic [CLW-1:0]  r_clr, n_clr;
    logic [TB-1:0]   r_fill, n_fill;
    logic [FB-1:0]   r_next_frame, n_next_frame;
    logic            r_o_valid, n_o_valid;

    // Payload of the request at work and of the result register.
    logic [PB-1:0]     r_page, n_page;
    logic [OB-1:0]     r_offset, n_offset;
    logic [FB-1:0]     r_frame, n_frame;
    logic [SRC_W-1:0]  r_source, n_source;
    logic              r_ev_valid, n_ev_valid;
    logic [PB-1:0]     r_ev_page, n_ev_page;
    t_page_entry       r_entry, n_entry;
    logic [ADDR_W-1:0] r_o_phys, n_o_phys;
    logic [SRC_W-1:0]  r_o_source, n_o_source;
    logic              r_o_ev_valid, n_o_ev_valid;
    logic [EVP_W-1:0]  r_o_ev_page, n_o_ev_page;

    // Memory ports.
    logic              a_we;
    logic [PB-1:0]     a_waddr, a_raddr;
    t_page_entry       a_wdata, a_rdata;
    logic              b_we;
    logic [BAW-1:0]    b_waddr, b_raddr;
    t_tag_entry        b_wdata, b_rdata;

    logic              out_free;
    logic              in_fire;
    logic [PB-1:0]     page_in;
    logic [TB-1:0]     fill_inc;
    logic [FB-1:0]     frame_inc;
    logic              tlb_hit;
    logic              old_in_tlb;

    tlbpt_ram #(
        .WIDTH ($bits(t_page_entry)),
        .DEPTH (PAGE_COUNT)
    ) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (a_wdata),
        .i_raddr (a_raddr),
        .o_rdata (a_rdata)
    );

    tlbpt_ram #(
        .WIDTH ($bits(t_tag_entry)),
        .DEPTH (BD)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (b_we),
        .i_waddr (b_waddr),
        .i_wdata (b_wdata),
        .i_raddr (b_raddr),
        .o_rdata (b_rdata)
    );

    // Handshakes and small helpers.
    assign out_free  = !r_o_valid || i_ready;
    assign o_ready   = (r_state == S_IDLE) || ((r_state == S_DONE) && out_free);
    assign in_fire   = i_valid && o_ready;
    assign page_in   = f_page_of(RAW_W'(i_logical_address >> OB));
    assign fill_inc  = (r_fill == TB'(TLB_ENTRIES - 1)) ? '0 : r_fill + 1'b1;
    assign frame_inc = (r_next_frame == FB'(FRAME_COUNT - 1)) ? '0 : r_next_frame + 1'b1;
    // A TLB slot counts only while the tag memory still names the page.
    assign tlb_hit    = r_entry.in_tlb && b_rdata.valid && (b_rdata.page == r_page);
    assign old_in_tlb = b_rdata.valid && (b_rdata.page == r_ev_page);

    // Sequencer: reads, decisions and write-backs of both memories.
    always_comb begin
        n_state      = r_state;
        n_clr        = r_clr;
        n_fill       = r_fill;
        n_next_frame = r_next_frame;
        n_page       = r_page;
        n_offset     = r_offset;
        n_frame      = r_frame;
        n_source     = r_source;
        n_ev_valid   = r_ev_valid;
        n_ev_page    = r_ev_page;
        n_entry      = r_entry;
        n_o_valid    = r_o_valid && !i_ready;
        n_o_phys     = r_o_phys;
        n_o_source   = r_o_source;
        n_o_ev_valid = r_o_ev_valid;
        n_o_ev_page  = r_o_ev_page;
        a_we         = 1'b0;
        a_waddr      = r_page;
        a_wdata      = '0;
        a_raddr      = page_in;
        b_we         = 1'b0;
        b_waddr      = {REGION_SLOT, XB'(r_fill)};
        b_wdata      = '0;
        b_raddr      = {REGION_SLOT, XB'(r_entry.slot)};

        unique case (r_state)
            S_CLEAR: begin
                a_we    = ({1'b0, r_clr} < (CLW + 1)'(PAGE_COUNT));
                a_waddr = PB'(r_clr);
                b_we    = ({1'b0, r_clr} < (CLW + 1)'(BD));
                b_waddr = BAW'(r_clr);
                if (r_clr == CLW'(CLR_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end

            S_IDLE, S_DONE: begin
                // Hand the finished result to the output register.
                if (r_state == S_DONE) begin
                    if (out_free) begin
                        n_o_valid    = 1'b1;
                        n_o_phys     = ADDR_W'({r_frame, r_offset});
                        n_o_source   = r_source;
                        n_o_ev_valid = r_ev_valid;
                        n_o_ev_page  = EVP_W'(r_ev_page);
                        n_state      = S_IDLE;
                    end
                end
                // Take the next request and start the page memory read.
                if (in_fire) begin
                    n_page     = page_in;
                    n_offset   = i_logical_address[OB-1:0];
                    n_ev_valid = 1'b0;
                    n_ev_page  = '0;
                    n_state    = S_LOOK_A;
                end
            end

            S_LOOK_A: begin
                // Page entry arrives; read the TLB slot it points at.
                n_entry = a_rdata;
                b_raddr = {REGION_SLOT, XB'(a_rdata.slot)};
                n_state = S_LOOK_B;
            end

            S_LOOK_B: begin
                if (tlb_hit) begin
                    n_frame  = r_entry.frame;
                    n_source = SRC_TLB;
                    n_state  = S_DONE;
                end else if (r_entry.map_valid) begin
                    // Table hit: FIFO refill of the TLB.
                    n_frame  = r_entry.frame;
                    n_source = SRC_TABLE;
                    b_we     = 1'b1;
                    b_waddr  = {REGION_SLOT, XB'(r_fill)};
                    b_wdata  = '{valid: 1'b1, page: r_page};
                    a_we     = 1'b1;
                    a_waddr  = r_page;
                    a_wdata  = '{map_valid: 1'b1, frame: r_entry.frame,
                                 in_tlb: 1'b1, slot: r_fill};
                    n_fill   = fill_inc;
                    n_state  = S_DONE;
                end else begin
                    // Page fault: look up who holds the next frame.
                    n_frame  = r_next_frame;
                    n_source = SRC_FAULT;
                    b_raddr  = {REGION_OWNER, XB'(r_next_frame)};
                    n_state  = S_OWNER;
                end
            end

            S_OWNER: begin
                // The frame now belongs to the faulting page.
                b_we         = 1'b1;
                b_waddr      = {REGION_OWNER, XB'(r_frame)};
                b_wdata      = '{valid: 1'b1, page: r_page};
                n_next_frame = frame_inc;
                if (b_rdata.valid) begin
                    n_ev_valid = 1'b1;
                    n_ev_page  = b_rdata.page;
                    a_raddr    = b_rdata.page;
                    n_state    = S_OLD_A;
                end else begin
                    n_state = S_INSERT;
                end
            end

            S_OLD_A: begin
                // Drop the old page's mapping and check its TLB slot.
                a_we    = 1'b1;
                a_waddr = r_ev_page;
                a_wdata = '0;
                n_entry = a_rdata;
                b_raddr = {REGION_SLOT, XB'(a_rdata.slot)};
                n_state = a_rdata.in_tlb ? S_OLD_B : S_INSERT;
            end

            S_OLD_B: begin
                if (old_in_tlb) begin
                    // Retarget the old page's TLB slot to the new page.
                    b_we    = 1'b1;
                    b_waddr = {REGION_SLOT, XB'(r_entry.slot)};
                    b_wdata = '{valid: 1'b1, page: r_page};
                    a_we    = 1'b1;
                    a_waddr = r_page;
                    a_wdata = '{map_valid: 1'b1, frame: r_frame,
                                in_tlb: 1'b1, slot: r_entry.slot};
                    n_state = S_DONE;
                end else begin
                    n_state = S_INSERT;
                end
            end

            S_INSERT: begin
                // Fault mapping goes into the TLB at the fill pointer.
                b_we    = 1'b1;
                b_waddr = {REGION_SLOT, XB'(r_fill)};
                b_wdata = '{valid: 1'b1, page: r_page};
                a_we    = 1'b1;
                a_waddr = r_page;
                a_wdata = '{map_valid: 1'b1, frame: r_frame, in_tlb: 1'b1, slot: r_fill};
                n_fill  = fill_inc;
                n_state = S_DONE;
            end

            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr        <= '0;
            r_fill       <= '0;
            r_next_frame <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_fill       <= n_fill;
            r_next_frame <= n_next_frame;
            r_o_valid    <= n_o_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_page       <= n_page;
        r_offset     <= n_offset;
        r_frame      <= n_frame;
        r_source     <= n_source;
        r_ev_valid   <= n_ev_valid;
        r_ev_page    <= n_ev_page;
        r_entry      <= n_entry;
        r_o_phys     <= n_o_phys;
        r_o_source   <= n_o_source;
        r_o_ev_valid <= n_o_ev_valid;
        r_o_ev_page  <= n_o_ev_page;
    end

    assign o_valid            = r_o_valid;
    assign o_physical_address = r_o_phys;
    assign o_source           = r_o_source;
    assign o_evicted_valid    = r_o_ev_valid;
    assign o_evicted_page     = r_o_ev_page;

endmodule

// ===== design/tlbpt_checker.sv =====
// ----------------------------------------------------------------------------
// TLB and page table translator: port checker
// Watches the top level's ports and flags results that cannot occur.
// ----------------------------------------------------------------------------
module tlbpt_checker
    import tlbpt_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic [ADDR_W-1:0] i_logical_address,
    input logic              o_valid,
    input logic              i_ready,
    input logic [ADDR_W-1:0] o_physical_address,
    input logic [SRC_W-1:0]  o_source,
    input logic              o_evicted_valid,
    input logic [EVP_W-1:0]  o_evicted_page
);

    // A stalled result holds.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_physical_address)
            && $stable(o_source) && $stable(o_evicted_valid) && $stable(o_evicted_page))
    else $error("stalled result changed");

    // Only the three defined source codes appear.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_source == SRC_TLB || o_source == SRC_TABLE || o_source == SRC_FAULT))
    else $error("undefined source code");

    // Only a page fault can take a frame from another page.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_evicted_valid |-> o_source == SRC_FAULT)
    else $error("eviction reported without a page fault");

    // The evicted page reads zero when nothing was evicted.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_evicted_valid |-> o_evicted_page == '0)
    else $error("evicted page set without an eviction");

    // A request is translated over several cycles: no request right after one.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
    else $error("request taken in the cycle after a request");

endmodule

bind tlb_page_table_translator tlbpt_checker u_checker (.*);

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// TLB and page table translator: self-checking testbench
// Sends logical addresses through the request channel and keeps a shadow copy
// of the TLB, the page table, the frame owners and both round-robin pointers.
// Every accepted request is translated in the shadow. Each result that comes
// back is checked field by field against the oldest waiting translation. The
// requests arrive in random bursts, and the result side stalls in changing
// patterns.
// ----------------------------------------------------------------------------
module testbench;
    import tlbpt_pkg::*;

    localparam int OFFSET_BITS = 10;
    localparam int PAGE_BITS   = ADDR_W - OFFSET_BITS;
    localparam int TLB_SLOTS   = 64;
    localparam int PAGE_SLOTS  = 64;
    localparam int FRAME_SLOTS = 64;
    localparam int RANDOM_REQS = 1200;

    // Stall patterns of the result side.
    localparam int RX_FLOW     = 0;
    localparam int RX_RANDOM   = 1;
    localparam int RX_THROTTLE = 2;
    localparam int RX_TOGGLE   = 3;

    // Shadow MMU: translates each accepted request and holds the results in order.
    class mmu_shadow;
        typedef struct packed {
            logic [ADDR_W-1:0] phys;
            logic [SRC_W-1:0]  src;
            logic              ev_valid;
            logic [EVP_W-1:0]  ev_page;
        } t_xlat;

        bit                 tlb_v  [TLB_SLOTS];
        bit [PAGE_BITS-1:0] tlb_pg [TLB_SLOTS];
        bit [PAGE_BITS-1:0] tlb_fr [TLB_SLOTS];
        bit [5:0]           fill_ptr;
        bit                 pm_v   [PAGE_SLOTS];
        bit [PAGE_BITS-1:0] pm_fr  [PAGE_SLOTS];
        bit                 fo_v   [FRAME_SLOTS];
        bit [PAGE_BITS-1:0] fo_pg  [FRAME_SLOTS];
        bit [5:0]           next_fr;
        t_xlat              expected_xlats[$];
        int                 errors;
        int                 n_hit, n_walk, n_fault, n_evict;

        function new();
            foreach (tlb_v[i]) tlb_v[i] = 1'b0;
            foreach (pm_v[i]) pm_v[i] = 1'b0;
            foreach (fo_v[i]) fo_v[i] = 1'b0;
            fill_ptr = '0;
            next_fr  = '0;
            errors   = 0;
            n_hit    = 0;
            n_walk   = 0;
            n_fault  = 0;
            n_evict  = 0;
        endfunction

        // FIFO refill of the TLB.
        function void fifo_insert(bit [PAGE_BITS-1:0] pg, bit [PAGE_BITS-1:0] fr);
            tlb_v[fill_ptr]  = 1'b1;
            tlb_pg[fill_ptr] = pg;
            tlb_fr[fill_ptr] = fr;
            fill_ptr         = fill_ptr + 1'b1;
        endfunction

        function void note_request(logic [ADDR_W-1:0] addr);
            bit [PAGE_BITS-1:0]   pg;
            bit [PAGE_BITS-1:0]   fr;
            bit [PAGE_BITS-1:0]   old;
            bit [OFFSET_BITS-1:0] ofs;
            bit                   hit;
            bit                   any;
            t_xlat                x;
            pg  = addr[ADDR_W-1:OFFSET_BITS];
            ofs = addr[OFFSET_BITS-1:0];
            hit = 1'b0;
            fr  = '0;
            x   = '0;
            // The lowest-numbered matching entry wins.
            for (int i = 0; i < TLB_SLOTS; i++) begin
                if (!hit && tlb_v[i] && tlb_pg[i] == pg) begin
                    hit = 1'b1;
                    fr  = tlb_fr[i];
                end
            end
            if (hit) begin
                x.src = SRC_TLB;
            end else if (pm_v[pg]) begin
                fr    = pm_fr[pg];
                x.src = SRC_TABLE;
                fifo_insert(pg, fr);
            end else begin
                // Page fault: take the next frame round-robin.
                fr    = next_fr;
                x.src = SRC_FAULT;
                if (fo_v[fr]) begin
                    old        = fo_pg[fr];
                    any        = 1'b0;
                    x.ev_valid = 1'b1;
                    x.ev_page  = old;
                    pm_v[old]  = 1'b0;
                    // TLB entries of the evicted page now point at the new page.
                    for (int i = 0; i < TLB_SLOTS; i++) begin
                        if (tlb_v[i] && tlb_pg[i] == old) begin
                            tlb_pg[i] = pg;
                            tlb_fr[i] = fr;
                            any       = 1'b1;
                        end
                    end
                    if (!any) fifo_insert(pg, fr);
                end else begin
                    fifo_insert(pg, fr);
                end
                pm_v[pg]  = 1'b1;
                pm_fr[pg] = fr;
                fo_v[fr]  = 1'b1;
                fo_pg[fr] = pg;
                next_fr   = fr + 1'b1;
            end
            x.phys = {fr, ofs};
            expected_xlats.push_back(x);
        endfunction

        function void check_result(logic [ADDR_W-1:0] phys, logic [SRC_W-1:0] src,
                                   logic ev_valid, logic [EVP_W-1:0] ev_page);
            t_xlat x;
            if (expected_xlats.size() == 0) begin
                $display("%0t: result with no request outstanding (phys %h src %0d)",
                         $time, phys, src);
                errors++;
                return;
            end
            x = expected_xlats.pop_front();
            case (x.src)
                SRC_TLB:   n_hit++;
                SRC_TABLE: n_walk++;
                default:   n_fault++;
            endcase
            if (x.ev_valid) n_evict++;
            if (phys !== x.phys) begin
                $display("%0t: physical_address expected %h actual %h", $time, x.phys, phys);
                errors++;
            end
            if (src !== x.src) begin
                $display("%0t: source expected %0d actual %0d", $time, x.src, src);
                errors++;
            end
            if (ev_valid !== x.ev_valid) begin
                $display("%0t: evicted_valid expected %b actual %b",
                         $time, x.ev_valid, ev_valid);
                errors++;
            end
            if (ev_page !== x.ev_page) begin
                $display("%0t: evicted_page expected %0d actual %0d",
                         $time, x.ev_page, ev_page);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [ADDR_W-1:0] i_logical_address;
    logic              o_valid;
    logic              i_ready;
    logic [ADDR_W-1:0] o_physical_address;
    logic [SRC_W-1:0]  o_source;
    logic              o_evicted_valid;
    logic [EVP_W-1:0]  o_evicted_page;

    mmu_shadow shadow;

    tlb_page_table_translator i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_logical_address  (i_logical_address),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_physical_address (o_physical_address),
        .o_source           (o_source),
        .o_evicted_valid    (o_evicted_valid),
        .o_evicted_page     (o_evicted_page)
    );

    // Clock with a period of 20.
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Drive one request from a falling edge and hold it until it is accepted.
    // Returns at the falling edge after acceptance.
    task automatic send_request(input logic [ADDR_W-1:0] addr);
        i_valid           <= 1'b1;
        i_logical_address <= addr;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        shadow.note_request(addr);
        @(negedge i_clk);
    endtask

    // Result side: cycles through randomly chosen stall patterns.
    initial begin
        int mode;
        int span;
        i_ready = 1'b0;
        forever begin
            mode = $urandom_range(RX_FLOW, RX_TOGGLE);
            span = $urandom_range(16, 96);
            repeat (span) begin
                @(negedge i_clk);
                case (mode)
                    RX_FLOW:     i_ready <= 1'b1;
                    RX_RANDOM:   i_ready <= 1'($urandom_range(0, 1));
                    RX_THROTTLE: i_ready <= ($urandom_range(0, 4) == 0);
                    default:     i_ready <= ~i_ready;
                endcase
            end
        end
    end

    // Check every accepted result.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            shadow.check_result(o_physical_address, o_source, o_evicted_valid,
                                o_evicted_page);
        end
    end

    // Request side: directed addresses first, then random bursts.
    initial begin
        logic [ADDR_W-1:0]    directed[$];
        logic [PAGE_BITS-1:0] recent[$];
        logic [ADDR_W-1:0]    addr;
        int                   sent;
        int                   burst;
        int                   gap;
        int                   drain;
        i_rst_n           = 1'b0;
        i_valid           = 1'b0;
        i_logical_address = '0;
        shadow            = new();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Field extremes, offset extremes, a repeated page for a TLB hit,
        // and alternating bit patterns.
        directed = '{16'h0000, 16'hFFFF, 16'h03FF, 16'hFC00, 16'h0001, 16'hFFFE,
                     16'hAAAA, 16'h5555, 16'h0400, 16'h0800, 16'h2AAA, 16'hD555,
                     16'h0000, 16'hFFFF};
        foreach (directed[k]) send_request(directed[k]);
        i_valid <= 1'b0;
        @(negedge i_clk);

        // Random part: half the requests revisit a recent page with a new offset.
        sent = 0;
        while (sent < RANDOM_REQS) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < RANDOM_REQS; k++) begin
                if (recent.size() != 0 && $urandom_range(0, 1)) begin
                    addr = {recent[$urandom_range(0, recent.size() - 1)],
                            OFFSET_BITS'($urandom_range(0, (1 << OFFSET_BITS) - 1))};
                end else begin
                    addr = ADDR_W'($urandom_range(0, 16'hFFFF));
                end
                recent.push_back(addr[ADDR_W-1:OFFSET_BITS]);
                if (recent.size() > 8) void'(recent.pop_front());
                send_request(addr);
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        i_valid <= 1'b0;

        // Drain the outstanding results, then let the block settle.
        drain = 0;
        while (shadow.expected_xlats.size() != 0 && drain < 5000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (20) @(posedge i_clk);
        if (shadow.expected_xlats.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, shadow.expected_xlats.size());
            shadow.errors++;
        end

        $display("Translated %0d requests: %0d TLB hits, %0d table hits, %0d faults",
                 directed.size() + RANDOM_REQS, shadow.n_hit, shadow.n_walk,
                 shadow.n_fault);
        $display("Faults that evicted a page: %0d; mismatches: %0d",
                 shadow.n_evict, shadow.errors);
        if (shadow.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #6000000;
        $display("Timeout waiting on the block");
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
design/tlbpt_pkg.sv
design/tlbpt_ram.sv
design/tlb_page_table_translator.sv
design/tlbpt_checker.sv
bench/testbench.sv
